// ----- rtl/core/tssr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssr_pkg
// Shared types and constants of the tile and sprite scanline renderer.
// ----------------------------------------------------------------------------
package tssr_pkg;

	localparam int VM_AW = 14;
	localparam int VM_DEPTH = 16384;
	localparam int OAM_AW = 8;
	localparam int OAM_DEPTH = 160;
	localparam int X_W = 9;
	localparam int CFG_IW = 3;

	localparam logic [1:0] KIND_VM = 2'd0;
	localparam logic [1:0] KIND_OAM = 2'd1;
	localparam logic [1:0] KIND_RENDER = 2'd2;

	localparam logic [CFG_IW-1:0] CFG_LCD = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_BGP = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_OBP0 = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_OBP1 = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_COLOR = 3'd4;

	localparam logic [7:0] LCD_RST = 8'd131;
	localparam logic [7:0] BGP_RST = 8'd252;
	localparam logic [7:0] OBP_RST = 8'd255;

	localparam int LCD_BG_EN = 0;
	localparam int LCD_OBJ_EN = 1;
	localparam int LCD_OBJ_TALL = 2;
	localparam int LCD_BG_MAP = 3;
	localparam int LCD_TILE_SEL = 4;
	localparam int LCD_WIN_EN = 5;
	localparam int LCD_WIN_MAP = 6;

	localparam logic [VM_AW-1:0] MAP_LO = 14'h1800;
	localparam logic [VM_AW-1:0] MAP_HI = 14'h1c00;
	localparam logic [VM_AW-1:0] TILE_SIGNED = 14'h0800;
	localparam logic [VM_AW-1:0] BANK1 = 14'h2000;
	localparam logic [7:0] WIN_X_MAX = 8'd166;
	localparam logic [7:0] WIN_X_OFS = 8'd7;
	localparam logic [7:0] OBJ_X_LIMIT = 8'd168;

	typedef struct packed {
		logic [1:0]  kind;
		logic [13:0] address;
		logic [7:0]  data;
		logic [7:0]  line;
		logic [7:0]  scroll_y;
		logic [7:0]  scroll_x;
		logic [7:0]  window_y;
		logic [7:0]  window_x;
	} in_word_t;

	typedef struct packed {
		logic [5:0] pixel_a;
		logic [5:0] pixel_b;
		logic [5:0] pixel_c;
		logic [5:0] pixel_d;
		logic [5:0] pixel_e;
		logic [5:0] pixel_f;
		logic [5:0] pixel_g;
		logic [5:0] pixel_h;
		logic [4:0] group_index;
		logic       last_group;
	} out_word_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_ACCEPT,
		OP_BG_START,
		OP_WIN_START,
		OP_ZERO,
		OP_MAP,
		OP_ATTR,
		OP_LO,
		OP_HI,
		OP_PIX,
		OP_SP_START,
		OP_SP_Y,
		OP_SP_X,
		OP_SP_T,
		OP_SP_F,
		OP_SP_TEST,
		OP_SP_LO,
		OP_SP_HI,
		OP_SP_RD,
		OP_SP_WR,
		OP_SP_NEXT,
		OP_OUT_START,
		OP_GRP_START,
		OP_OUT_RD,
		OP_OUT_CAP,
		OP_OUT_NEXT
	} op_t;

	typedef struct packed {
		logic clr_last;
		logic render_req;
		logic bg_on;
		logic win_phase;
		logic win_on;
		logic x_last;
		logic spr_on;
		logic sp_vis;
		logic sp_px_last;
		logic sp_last;
		logic k_last;
		logic g_last;
	} dp_status_t;

endpackage

// ----- rtl/core/tssr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssr_ctrl
// Sequencer of the renderer: memory clear, writes, background and window
// passes, sprite pass and word output.
// ----------------------------------------------------------------------------
module tssr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  tssr_pkg::dp_status_t  status,
	output tssr_pkg::op_t         op
);

	typedef enum logic [25:0] {
		ST_CLR     = 26'd1 << 0,
		ST_IDLE    = 26'd1 << 1,
		ST_RINIT   = 26'd1 << 2,
		ST_ZERO    = 26'd1 << 3,
		ST_MAP     = 26'd1 << 4,
		ST_ATTR    = 26'd1 << 5,
		ST_LO      = 26'd1 << 6,
		ST_HI      = 26'd1 << 7,
		ST_PIX     = 26'd1 << 8,
		ST_WINCHK  = 26'd1 << 9,
		ST_SPCHK   = 26'd1 << 10,
		ST_SP_Y    = 26'd1 << 11,
		ST_SP_X    = 26'd1 << 12,
		ST_SP_T    = 26'd1 << 13,
		ST_SP_F    = 26'd1 << 14,
		ST_SP_TEST = 26'd1 << 15,
		ST_SP_LO   = 26'd1 << 16,
		ST_SP_HI   = 26'd1 << 17,
		ST_SP_RD   = 26'd1 << 18,
		ST_SP_WR   = 26'd1 << 19,
		ST_SP_NEXT = 26'd1 << 20,
		ST_OUTINIT = 26'd1 << 21,
		ST_GRP     = 26'd1 << 22,
		ST_ORD     = 26'd1 << 23,
		ST_OCAP    = 26'd1 << 24,
		ST_SEND    = 26'd1 << 25
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SEND);

	always_comb begin
		state_d = state_q;
		op = tssr_pkg::OP_NONE;
		case (state_q)
			ST_CLR: begin
				op = tssr_pkg::OP_CLR;
				if (status.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					op = tssr_pkg::OP_ACCEPT;
					if (status.render_req) state_d = ST_RINIT;
				end
			end
			ST_RINIT: begin
				op = tssr_pkg::OP_BG_START;
				state_d = status.bg_on ? ST_MAP : ST_ZERO;
			end
			ST_ZERO: begin
				op = tssr_pkg::OP_ZERO;
				if (status.x_last) state_d = ST_WINCHK;
			end
			ST_MAP: begin
				op = tssr_pkg::OP_MAP;
				state_d = ST_ATTR;
			end
			ST_ATTR: begin
				op = tssr_pkg::OP_ATTR;
				state_d = ST_LO;
			end
			ST_LO: begin
				op = tssr_pkg::OP_LO;
				state_d = ST_HI;
			end
			ST_HI: begin
				op = tssr_pkg::OP_HI;
				state_d = ST_PIX;
			end
			ST_PIX: begin
				op = tssr_pkg::OP_PIX;
				if (!status.x_last) state_d = ST_MAP;
				else if (status.win_phase) state_d = ST_SPCHK;
				else state_d = ST_WINCHK;
			end
			ST_WINCHK: begin
				if (status.win_on) begin
					op = tssr_pkg::OP_WIN_START;
					state_d = ST_MAP;
				end else begin
					state_d = ST_SPCHK;
				end
			end
			ST_SPCHK: begin
				if (status.spr_on) begin
					op = tssr_pkg::OP_SP_START;
					state_d = ST_SP_Y;
				end else begin
					state_d = ST_OUTINIT;
				end
			end
			ST_SP_Y: begin
				op = tssr_pkg::OP_SP_Y;
				state_d = ST_SP_X;
			end
			ST_SP_X: begin
				op = tssr_pkg::OP_SP_X;
				state_d = ST_SP_T;
			end
			ST_SP_T: begin
				op = tssr_pkg::OP_SP_T;
				state_d = ST_SP_F;
			end
			ST_SP_F: begin
				op = tssr_pkg::OP_SP_F;
				state_d = ST_SP_TEST;
			end
			ST_SP_TEST: begin
				op = tssr_pkg::OP_SP_TEST;
				state_d = status.sp_vis ? ST_SP_LO : ST_SP_NEXT;
			end
			ST_SP_LO: begin
				op = tssr_pkg::OP_SP_LO;
				state_d = ST_SP_HI;
			end
			ST_SP_HI: begin
				op = tssr_pkg::OP_SP_HI;
				state_d = ST_SP_RD;
			end
			ST_SP_RD: begin
				op = tssr_pkg::OP_SP_RD;
				state_d = ST_SP_WR;
			end
			ST_SP_WR: begin
				op = tssr_pkg::OP_SP_WR;
				state_d = status.sp_px_last ? ST_SP_NEXT : ST_SP_RD;
			end
			ST_SP_NEXT: begin
				op = tssr_pkg::OP_SP_NEXT;
				state_d = status.sp_last ? ST_OUTINIT : ST_SP_Y;
			end
			ST_OUTINIT: begin
				op = tssr_pkg::OP_OUT_START;
				state_d = ST_GRP;
			end
			ST_GRP: begin
				op = tssr_pkg::OP_GRP_START;
				state_d = ST_ORD;
			end
			ST_ORD: begin
				op = tssr_pkg::OP_OUT_RD;
				state_d = ST_OCAP;
			end
			ST_OCAP: begin
				op = tssr_pkg::OP_OUT_CAP;
				state_d = status.k_last ? ST_SEND : ST_ORD;
			end
			ST_SEND: begin
				if (out_ready) begin
					op = tssr_pkg::OP_OUT_NEXT;
					state_d = status.g_last ? ST_IDLE : ST_GRP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/tssr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssr_dp
// Datapath of the renderer: video memory, sprite table, line buffer,
// configuration registers, counters and pixel composition.
// ----------------------------------------------------------------------------
module tssr_dp #(
	parameter int LINE_WIDTH = 160,
	parameter int VISIBLE_LINES = 144,
	parameter int SPRITE_COUNT = 40,
	parameter int PIXELS_PER_RESULT = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tssr_pkg::op_t                    op,
	input  tssr_pkg::in_word_t               in_data,
	input  logic                             cfg_we,
	input  logic [tssr_pkg::CFG_IW-1:0]      cfg_index,
	input  logic [7:0]                       cfg_data,
	output tssr_pkg::dp_status_t             status,
	output tssr_pkg::out_word_t              out_data
);

	localparam int LB_AW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
	localparam int SW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
	localparam int KW = (PIXELS_PER_RESULT > 1) ? $clog2(PIXELS_PER_RESULT) : 1;
	localparam int NG = (LINE_WIDTH + PIXELS_PER_RESULT - 1) / PIXELS_PER_RESULT;
	localparam int GW = (NG > 1) ? $clog2(NG) : 1;
	localparam int XW = tssr_pkg::X_W;
	localparam int AW = tssr_pkg::VM_AW;

	function automatic logic [1:0] shade(input logic [7:0] pal, input logic [1:0] c);
		shade = pal[{c, 1'b0} +: 2];
	endfunction

	// memories
	logic [7:0] vm_mem [tssr_pkg::VM_DEPTH];
	logic [7:0] oam_mem [tssr_pkg::OAM_DEPTH];
	logic [tssr_pkg::OAM_DEPTH-1:0] oam_v_q;
	logic [6:0] lb_mem [LINE_WIDTH];

	logic [7:0] lcd_q, bgp_q, obp0_q, obp1_q;
	logic color_q;
	logic [7:0] line_q, scy_q, scx_q, wy_q, wx_q;
	logic [AW-1:0] clr_q;
	logic [XW-1:0] x_q;
	logic win_q;
	logic [SW-1:0] s_q;
	logic [KW-1:0] k_q;
	logic [GW-1:0] g_q;
	logic [XW-1:0] xb_q;

	logic [7:0] vm_rd_q, oam_rd_q;
	logic oam_ok_q;
	logic [6:0] lb_rd_q;
	logic [7:0] idx_q, attr_q, lo_q, hi_q;
	logic [AW-1:0] tile_q;
	logic [7:0] oy_q, ox_q, ot_q, of_q;
	logic [5:0] pix_q [8];

	logic [7:0] oam_rd;
	logic [7:0] ycoord, xcoord;
	logic [AW-1:0] map_addr, tile_base, tile_addr, sp_addr;
	logic [7:0] attr_now;
	logic [2:0] row, bsel, col, sbit;
	logic [1:0] c_bg, c_sp;
	logic [5:0] bg_pix;
	logic tall;
	logic sp_yhit, sp_xhit;
	logic [7:0] dy, ot_m;
	logic [3:0] py;
	logic [XW-1:0] x0, x1, win_first, out_x;
	logic px_nz, sp_wr;
	logic [5:0] sp_val;

	logic [AW-1:0] vm_addr;
	logic vm_we;
	logic [7:0] vm_wdata;
	logic [tssr_pkg::OAM_AW-1:0] oam_ra;
	logic [1:0] oam_off;
	logic lb_we;
	logic [6:0] lb_wdata;
	logic [LB_AW-1:0] lb_raddr;
	logic oam_wr;

	assign oam_rd = oam_ok_q ? oam_rd_q : 8'h00;

	// background and window addressing
	assign ycoord = win_q ? 8'(line_q - wy_q) : 8'(line_q + scy_q);
	assign xcoord = win_q ? 8'(x_q[7:0] + tssr_pkg::WIN_X_OFS - wx_q) : 8'(x_q[7:0] + scx_q);
	assign map_addr = ((win_q ? lcd_q[tssr_pkg::LCD_WIN_MAP] : lcd_q[tssr_pkg::LCD_BG_MAP])
		? tssr_pkg::MAP_HI : tssr_pkg::MAP_LO)
		+ {4'b0, ycoord[7:3], 5'b0} + {9'b0, xcoord[7:3]};
	assign attr_now = color_q ? vm_rd_q : 8'h00;
	assign tile_base = lcd_q[tssr_pkg::LCD_TILE_SEL] ? {2'b0, idx_q, 4'b0}
		: tssr_pkg::TILE_SIGNED + {2'b0, ~idx_q[7], idx_q[6:0], 4'b0};
	assign row = attr_now[6] ? ~ycoord[2:0] : ycoord[2:0];
	assign tile_addr = tile_base + (attr_now[3] ? tssr_pkg::BANK1 : '0) + {10'b0, row, 1'b0};
	assign bsel = attr_q[5] ? xcoord[2:0] : ~xcoord[2:0];
	assign c_bg = {vm_rd_q[bsel], lo_q[bsel]};
	assign bg_pix = color_q ? {1'b0, attr_q[2:0], c_bg} : {1'b1, 3'b000, shade(bgp_q, c_bg)};
	assign win_first = (wx_q < tssr_pkg::WIN_X_OFS) ? '0 : {1'b0, 8'(wx_q - tssr_pkg::WIN_X_OFS)};

	// sprite fetch and test
	assign tall = lcd_q[tssr_pkg::LCD_OBJ_TALL];
	assign sp_yhit = !(({1'b0, line_q} + (tall ? 9'd0 : 9'd8)) >= {1'b0, oy_q})
		&& !(({1'b0, line_q} + 9'd16) < {1'b0, oy_q});
	assign sp_xhit = (ox_q != 8'd0) && (ox_q < tssr_pkg::OBJ_X_LIMIT)
		&& ({1'b0, ox_q} < 9'(LINE_WIDTH + 8));
	assign dy = 8'(line_q + 8'd16 - oy_q);
	assign py = oam_rd[6] ? (tall ? ~dy[3:0] : {1'b0, ~dy[2:0]}) : dy[3:0];
	assign ot_m = tall ? {ot_q[7:1], 1'b0} : ot_q;
	assign sp_addr = {2'b0, ot_m, 4'b0} + {9'b0, py, 1'b0}
		+ ((color_q && oam_rd[3]) ? tssr_pkg::BANK1 : '0);
	assign x0 = (ox_q < 8'd8) ? '0 : {1'b0, 8'(ox_q - 8'd8)};
	assign x1 = (({1'b0, ox_q} - 9'd1) > 9'(LINE_WIDTH - 1)) ? 9'(LINE_WIDTH - 1)
		: ({1'b0, ox_q} - 9'd1);
	assign col = 3'(x_q[2:0] - ox_q[2:0]);
	assign sbit = of_q[5] ? col : ~col;
	assign c_sp = {hi_q[sbit], lo_q[sbit]};
	assign px_nz = (lb_rd_q[1:0] != 2'b00);

	always_comb begin
		if (color_q) begin
			sp_wr = (c_sp != 2'b00) && (!lcd_q[tssr_pkg::LCD_BG_EN]
				|| (!(lb_rd_q[6] && px_nz) && !(of_q[7] && px_nz)));
			sp_val = {1'b1, of_q[2:0], c_sp};
		end else begin
			sp_wr = (c_sp != 2'b00) && !(of_q[7] && (lb_rd_q[1:0] != bgp_q[1:0]));
			sp_val = {1'b0, of_q[4], 2'b00, shade(of_q[4] ? obp1_q : obp0_q, c_sp)};
		end
	end

	assign out_x = xb_q + XW'(k_q);

	// memory port selection
	always_comb begin
		vm_addr = map_addr;
		vm_we = 1'b0;
		vm_wdata = in_data.data;
		oam_off = 2'd0;
		lb_we = 1'b0;
		lb_wdata = {1'b0, 6'd0};
		lb_raddr = x_q[LB_AW-1:0];
		case (op)
			tssr_pkg::OP_CLR: begin
				vm_addr = clr_q;
				vm_we = 1'b1;
				vm_wdata = 8'h00;
			end
			tssr_pkg::OP_ACCEPT: begin
				vm_addr = in_data.address;
				vm_we = (in_data.kind == tssr_pkg::KIND_VM);
			end
			tssr_pkg::OP_ATTR: vm_addr = map_addr + tssr_pkg::BANK1;
			tssr_pkg::OP_LO: vm_addr = tile_addr;
			tssr_pkg::OP_HI, tssr_pkg::OP_SP_LO: vm_addr = tile_q + 14'd1;
			tssr_pkg::OP_SP_TEST: vm_addr = sp_addr;
			tssr_pkg::OP_ZERO: lb_we = 1'b1;
			tssr_pkg::OP_PIX: begin
				lb_we = 1'b1;
				lb_wdata = {color_q & attr_q[7], bg_pix};
			end
			tssr_pkg::OP_SP_X: oam_off = 2'd1;
			tssr_pkg::OP_SP_T: oam_off = 2'd2;
			tssr_pkg::OP_SP_F: oam_off = 2'd3;
			tssr_pkg::OP_SP_WR: begin
				lb_we = sp_wr;
				lb_wdata = {lb_rd_q[6], sp_val};
			end
			tssr_pkg::OP_OUT_RD: lb_raddr = out_x[LB_AW-1:0];
			default: ;
		endcase
	end

	assign oam_ra = {6'(s_q), oam_off};
	assign oam_wr = (op == tssr_pkg::OP_ACCEPT) && (in_data.kind == tssr_pkg::KIND_OAM)
		&& (in_data.address < 14'(tssr_pkg::OAM_DEPTH));

	always_ff @(posedge clk) begin
		if (vm_we) vm_mem[vm_addr] <= vm_wdata;
		vm_rd_q <= vm_mem[vm_addr];
	end

	always_ff @(posedge clk) begin
		if (oam_wr) oam_mem[in_data.address[tssr_pkg::OAM_AW-1:0]] <= in_data.data;
		oam_rd_q <= oam_mem[oam_ra];
	end

	always_ff @(posedge clk) begin
		if (lb_we) lb_mem[x_q[LB_AW-1:0]] <= lb_wdata;
		lb_rd_q <= lb_mem[lb_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oam_v_q <= '0;
			oam_ok_q <= 1'b0;
		end else begin
			if (oam_wr) oam_v_q[in_data.address[tssr_pkg::OAM_AW-1:0]] <= 1'b1;
			oam_ok_q <= (oam_ra < 8'(tssr_pkg::OAM_DEPTH)) && oam_v_q[oam_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_q <= tssr_pkg::LCD_RST;
			bgp_q <= tssr_pkg::BGP_RST;
			obp0_q <= tssr_pkg::OBP_RST;
			obp1_q <= tssr_pkg::OBP_RST;
			color_q <= 1'b0;
			clr_q <= '0;
			x_q <= '0;
			win_q <= 1'b0;
			s_q <= '0;
			k_q <= '0;
			g_q <= '0;
			xb_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tssr_pkg::CFG_LCD: lcd_q <= cfg_data;
					tssr_pkg::CFG_BGP: bgp_q <= cfg_data;
					tssr_pkg::CFG_OBP0: obp0_q <= cfg_data;
					tssr_pkg::CFG_OBP1: obp1_q <= cfg_data;
					tssr_pkg::CFG_COLOR: color_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (op)
				tssr_pkg::OP_CLR: clr_q <= clr_q + 14'd1;
				tssr_pkg::OP_BG_START: begin
					x_q <= '0;
					win_q <= 1'b0;
				end
				tssr_pkg::OP_WIN_START: begin
					x_q <= win_first;
					win_q <= 1'b1;
				end
				tssr_pkg::OP_ZERO, tssr_pkg::OP_PIX, tssr_pkg::OP_SP_WR: x_q <= x_q + 9'd1;
				tssr_pkg::OP_SP_HI: x_q <= x0;
				tssr_pkg::OP_SP_START: s_q <= SW'(SPRITE_COUNT - 1);
				tssr_pkg::OP_SP_NEXT: s_q <= s_q - SW'(1);
				tssr_pkg::OP_OUT_START: begin
					g_q <= '0;
					xb_q <= '0;
				end
				tssr_pkg::OP_GRP_START: k_q <= '0;
				tssr_pkg::OP_OUT_CAP: k_q <= k_q + KW'(1);
				tssr_pkg::OP_OUT_NEXT: begin
					g_q <= g_q + GW'(1);
					xb_q <= xb_q + XW'(PIXELS_PER_RESULT);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			tssr_pkg::OP_ACCEPT: begin
				line_q <= in_data.line;
				scy_q <= in_data.scroll_y;
				scx_q <= in_data.scroll_x;
				wy_q <= in_data.window_y;
				wx_q <= in_data.window_x;
			end
			tssr_pkg::OP_ATTR: idx_q <= vm_rd_q;
			tssr_pkg::OP_LO: begin
				attr_q <= attr_now;
				tile_q <= tile_addr;
			end
			tssr_pkg::OP_HI, tssr_pkg::OP_SP_LO: lo_q <= vm_rd_q;
			tssr_pkg::OP_SP_X: oy_q <= oam_rd;
			tssr_pkg::OP_SP_T: ox_q <= oam_rd;
			tssr_pkg::OP_SP_F: ot_q <= oam_rd;
			tssr_pkg::OP_SP_TEST: begin
				of_q <= oam_rd;
				tile_q <= sp_addr;
			end
			tssr_pkg::OP_SP_HI: hi_q <= vm_rd_q;
			tssr_pkg::OP_GRP_START: begin
				for (int i = 0; i < 8; i++) pix_q[i] <= 6'd0;
			end
			tssr_pkg::OP_OUT_CAP: begin
				pix_q[3'(k_q)] <= (out_x < 9'(LINE_WIDTH)) ? lb_rd_q[5:0] : 6'd0;
			end
			default: ;
		endcase
	end

	always_comb begin
		status.clr_last = (clr_q == 14'h3fff);
		status.render_req = (in_data.kind == tssr_pkg::KIND_RENDER)
			&& ({1'b0, in_data.line} < 9'(VISIBLE_LINES));
		status.bg_on = lcd_q[tssr_pkg::LCD_BG_EN] | color_q;
		status.win_phase = win_q;
		status.win_on = lcd_q[tssr_pkg::LCD_WIN_EN] && (line_q >= wy_q)
			&& (wx_q <= tssr_pkg::WIN_X_MAX) && (win_first < 9'(LINE_WIDTH));
		status.x_last = (x_q == 9'(LINE_WIDTH - 1));
		status.spr_on = lcd_q[tssr_pkg::LCD_OBJ_EN];
		status.sp_vis = sp_yhit && sp_xhit;
		status.sp_px_last = (x_q == x1);
		status.sp_last = (s_q == '0);
		status.k_last = (k_q == KW'(PIXELS_PER_RESULT - 1));
		status.g_last = (g_q == GW'(NG - 1));
	end

	always_comb begin
		out_data.pixel_a = pix_q[0];
		out_data.pixel_b = pix_q[1];
		out_data.pixel_c = pix_q[2];
		out_data.pixel_d = pix_q[3];
		out_data.pixel_e = pix_q[4];
		out_data.pixel_f = pix_q[5];
		out_data.pixel_g = pix_q[6];
		out_data.pixel_h = pix_q[7];
		out_data.group_index = 5'(g_q);
		out_data.last_group = (g_q == GW'(NG - 1));
	end

endmodule

// ----- rtl/core/tile_sprite_scanline_renderer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_sprite_scanline_renderer
// Tile map, window and sprite scanline renderer with 16 KiB video memory
// and a sprite attribute table.
// ----------------------------------------------------------------------------
// Input words carry a video memory write, a sprite table write or a render
// request. A write leaves the block ready. A render of a visible line returns
// ceil(LINE_WIDTH / PIXELS_PER_RESULT) output words of pixel codes, left to
// right; lines at or past VISIBLE_LINES return nothing.
// Only one word is in work at a time: in_ready is high while idle.
// Render passes share the single-port video memory and the line buffer:
//   background fetches map, attribute and tile bytes for each pixel (or
//   zeroes the line when off in mono mode), window does so per covered
//   pixel, each sprite entry is read and tested, a sprite on the line gets
//   its tile row and covered pixels merged, then output words are built.
// After reset the block sweeps all 16384 video memory bytes to zero and
// holds in_ready low; configuration writes are taken at any time.
// A stalled out_ready holds the current word and pauses the render.
// ----------------------------------------------------------------------------
module tile_sprite_scanline_renderer #(
	parameter int LINE_WIDTH = 160,
	parameter int VISIBLE_LINES = 144,
	parameter int SPRITE_COUNT = 40,
	parameter int PIXELS_PER_RESULT = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  tssr_pkg::in_word_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output tssr_pkg::out_word_t           out_data,
	input  logic                          cfg_we,
	input  logic [tssr_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [7:0]                    cfg_data
);

	tssr_pkg::dp_status_t status;
	tssr_pkg::op_t op;

	tssr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.op        (op)
	);

	tssr_dp #(
		.LINE_WIDTH        (LINE_WIDTH),
		.VISIBLE_LINES     (VISIBLE_LINES),
		.SPRITE_COUNT      (SPRITE_COUNT),
		.PIXELS_PER_RESULT (PIXELS_PER_RESULT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.out_data  (out_data)
	);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while output word pending");

	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.kind == tssr_pkg::KIND_RENDER)
		&& ({1'b0, in_data.line} < 9'(VISIBLE_LINES)) |=> !in_ready)
		else $error("render accepted but block still ready");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.last_group |=> in_ready)
		else $error("block not idle after last word");

	a_word_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("output word repeated without assembly");

endmodule

// ----- test/tb_tile_sprite_scanline_renderer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_sprite_scanline_renderer
// Self-checking testbench of the tile and sprite scanline renderer.
// ----------------------------------------------------------------------------
// A line predictor keeps its own copy of video memory, the sprite table and
// the registers, composes each rendered line and queues the 20 expected
// groups. Output words are checked field by field against that queue. The
// run goes through several register settings with directed words first,
// then biased random traffic, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_tile_sprite_scanline_renderer;
	import tssr_pkg::*;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int GROUPS = 20;
	localparam int SETTLE = 3000;
	localparam int LIMIT = 4000000;

	class line_scoreboard;
		bit [7:0] vmem [VM_DEPTH];
		bit [7:0] oamt [OAM_DEPTH];
		bit [7:0] lcdc, bgp, obp0, obp1;
		bit color;
		bit [5:0] pix [160];
		bit prio [160];
		out_word_t groups_q [$];
		int errors, results, renders, writes;

		function new();
			lcdc = LCD_RST;
			bgp = BGP_RST;
			obp0 = OBP_RST;
			obp1 = OBP_RST;
			color = 0;
		endfunction

		function void set_reg(logic [CFG_IW-1:0] idx, logic [7:0] val);
			case (idx)
				CFG_LCD: lcdc = val;
				CFG_BGP: bgp = val;
				CFG_OBP0: obp0 = val;
				CFG_OBP1: obp1 = val;
				CFG_COLOR: color = val[0];
				default: ;
			endcase
		endfunction

		function int shade(bit [7:0] pal, int c);
			return (pal >> ((c & 3) * 2)) & 3;
		endfunction

		function int rd(int a);
			return vmem[a & 16383];
		endfunction

		function void map_px(int x, int mapaddr, int py, int bx);
			int idx, attr, tile, row, bitn, c;
			idx = rd(mapaddr);
			attr = color ? rd(mapaddr + 'h2000) : 0;
			tile = lcdc[LCD_TILE_SEL] ? idx * 16 : 'h0800 + ((idx + 'h80) & 'hff) * 16;
			row = (attr & 'h40) ? 7 - (py & 7) : (py & 7);
			bitn = (attr & 'h20) ? (bx & 7) : 7 - (bx & 7);
			if (attr & 'h08) tile += 'h2000;
			tile += 2 * row;
			c = ((rd(tile) >> bitn) & 1) | (((rd(tile + 1) >> bitn) & 1) << 1);
			if (color) begin
				pix[x] = ((attr & 7) << 2) + c;
				prio[x] = attr[7];
			end else begin
				pix[x] = shade(bgp, c) | 'h20;
			end
		endfunction

		function void draw_sprites(int ln);
			bit tall;
			int oy, ox, ot, fl, py, addr, lo, hi, x0, x1, col, bitn, c, px;
			bit bg_off, ok;
			tall = lcdc[LCD_OBJ_TALL];
			for (int s = 39; s >= 0; s--) begin
				oy = oamt[4*s];
				ox = oamt[4*s+1];
				ot = oamt[4*s+2] & (tall ? 'hfe : 'hff);
				fl = oamt[4*s+3];
				if (ln + (tall ? 0 : 8) >= oy || ln + 16 < oy) continue;
				if (ox == 0 || ox >= 168) continue;
				py = (ln + 16 - oy) & 15;
				if (fl & 'h40) py = (tall ? 15 : 7) - py;
				addr = ot * 16 + 2 * py;
				if (color) addr += (fl & 'h08) << 10;
				lo = rd(addr);
				hi = rd(addr + 1);
				x0 = ox - 8 < 0 ? 0 : ox - 8;
				x1 = ox - 1 > 159 ? 159 : ox - 1;
				for (int x = x0; x <= x1; x++) begin
					col = (x - (ox - 8)) & 7;
					bitn = (fl & 'h20) ? col : 7 - col;
					c = ((lo >> bitn) & 1) | (((hi >> bitn) & 1) << 1);
					px = pix[x];
					if (color) begin
						bg_off = c != 0 && !lcdc[LCD_BG_EN];
						ok = c != 0 && !(prio[x] && (px & 3)) && !((fl & 'h80) && (px & 3));
						if (bg_off || ok) pix[x] = ((fl & 7) << 2) + c + 'h20;
					end else if (c != 0 && !((fl & 'h80) && (px & 3) != shade(bgp, 0))) begin
						pix[x] = ((fl & 'h10) ? shade(obp1, c) : shade(obp0, c)) | (fl & 'h10);
					end
				end
			end
		endfunction

		function void render_line(int ln, int scy, int scx, int wy, int wx);
			int by, wl, mapb, first;
			out_word_t o;
			foreach (pix[i]) begin
				pix[i] = 0;
				prio[i] = 0;
			end
			if (lcdc[LCD_BG_EN] || color) begin
				by = (ln + scy) & 255;
				mapb = (lcdc[LCD_BG_MAP] ? 'h1c00 : 'h1800) + (by >> 3) * 'h20;
				for (int x = 0; x < 160; x++)
					map_px(x, mapb + (((x + scx) & 255) >> 3), by & 7, (x + scx) & 7);
			end
			if (lcdc[LCD_WIN_EN] && ln >= wy && wx <= 166) begin
				wl = ln - wy;
				mapb = (lcdc[LCD_WIN_MAP] ? 'h1c00 : 'h1800) + (wl >> 3) * 'h20;
				first = wx < 7 ? 0 : wx - 7;
				for (int x = first; x < 160; x++)
					map_px(x, mapb + (((x + 7 - wx) & 255) >> 3), wl & 7, (x + 7 - wx) & 7);
			end
			if (lcdc[LCD_OBJ_EN]) draw_sprites(ln);
			for (int g = 0; g < GROUPS; g++) begin
				o = '{pix[8*g], pix[8*g+1], pix[8*g+2], pix[8*g+3], pix[8*g+4],
					pix[8*g+5], pix[8*g+6], pix[8*g+7], 5'(g), g == GROUPS - 1};
				groups_q.push_back(o);
			end
		endfunction

		function void note_word(in_word_t w);
			case (w.kind)
				KIND_VM: begin
					vmem[w.address] = w.data;
					writes++;
				end
				KIND_OAM: begin
					if (w.address < OAM_DEPTH) oamt[w.address] = w.data;
					writes++;
				end
				KIND_RENDER: begin
					if (w.line < 144) begin
						renders++;
						render_line(w.line, w.scroll_y, w.scroll_x, w.window_y, w.window_x);
					end
				end
				default: ;
			endcase
		endfunction

		task report(string what, int g, int got, int want);
			$display("mismatch: %s group %0d got %0h want %0h", what, g, got, want);
			errors++;
		endtask

		task check_word(out_word_t w);
			out_word_t e;
			bit [5:0] gp [8];
			bit [5:0] ep [8];
			if (groups_q.size() == 0) begin
				report("unexpected word", w.group_index, w, 0);
				return;
			end
			e = groups_q.pop_front();
			results++;
			gp = '{w.pixel_a, w.pixel_b, w.pixel_c, w.pixel_d,
				w.pixel_e, w.pixel_f, w.pixel_g, w.pixel_h};
			ep = '{e.pixel_a, e.pixel_b, e.pixel_c, e.pixel_d,
				e.pixel_e, e.pixel_f, e.pixel_g, e.pixel_h};
			foreach (gp[k])
				if (gp[k] !== ep[k]) report($sformatf("pixel %0d", k), e.group_index, gp[k], ep[k]);
			if (w.group_index !== e.group_index)
				report("group_index", e.group_index, w.group_index, e.group_index);
			if (w.last_group !== e.last_group)
				report("last_group", e.group_index, w.last_group, e.last_group);
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid = 0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_word_t out_data;
	logic cfg_we = 0;
	logic [CFG_IW-1:0] cfg_index = CFG_LCD;
	logic [7:0] cfg_data = 0;

	line_scoreboard sb = new();
	int cycles;
	int burst_left;
	int rx_cnt;

	tile_sprite_scanline_renderer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		rx_cnt++;
		if (out_valid && out_ready) sb.check_word(out_data);
		if ((rx_cnt % 300) < 80)
			out_ready <= 1;
		else if ((rx_cnt % 300) < 100)
			out_ready <= 0;
		else
			out_ready <= $urandom_range(0, 3) != 0;
	end

	task send_word(in_word_t w);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_word(w);
	endtask

	task write_reg(logic [CFG_IW-1:0] idx, logic [7:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	task settle();
		in_valid <= 0;
		burst_left = 0;
		while (sb.groups_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task set_regs(logic [7:0] lc, logic [7:0] bp, logic [7:0] p0, logic [7:0] p1, bit cm);
		write_reg(CFG_LCD, lc);
		write_reg(CFG_BGP, bp);
		write_reg(CFG_OBP0, p0);
		write_reg(CFG_OBP1, p1);
		write_reg(CFG_COLOR, cm);
	endtask

	function in_word_t mk(logic [1:0] k, int a, int d);
		in_word_t w;
		w = {$urandom(), $urandom()};
		w.kind = k;
		w.address = a;
		w.data = d;
		return w;
	endfunction

	function in_word_t mk_render(int ln, int scy, int scx, int wy, int wx);
		in_word_t w;
		w = mk(KIND_RENDER, $urandom, $urandom);
		w.line = ln;
		w.scroll_y = scy;
		w.scroll_x = scx;
		w.window_y = wy;
		w.window_x = wx;
		return w;
	endfunction

	function in_word_t rand_word();
		int r, sel, a, k;
		in_word_t w;
		r = $urandom_range(0, 99);
		w = {$urandom(), $urandom()};
		if (r < 40) begin
			sel = $urandom_range(0, 9);
			case (sel)
				0, 1: a = $urandom_range(0, 127);
				2: a = 'h0800 + $urandom_range(0, 63);
				3: a = 'h1000 + $urandom_range(0, 63);
				4, 5, 6: a = 'h1800 + $urandom_range(0, 2047);
				7: a = 'h3800 + $urandom_range(0, 2047);
				8: a = 'h2000 + $urandom_range(0, 127);
				default: a = $urandom_range(0, 16383);
			endcase
			w.kind = KIND_VM;
			w.address = a;
			if (sel >= 4 && sel <= 6 && $urandom_range(0, 1))
				w.data = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(128, 131);
		end else if (r < 65) begin
			w.kind = KIND_OAM;
			a = $urandom_range(0, 19) == 0 ? $urandom_range(0, 16383) : $urandom_range(0, 159);
			w.address = a;
			k = a & 3;
			if (a < 160 && $urandom_range(0, 4) != 0)
				case (k)
					0: w.data = $urandom_range(0, 160);
					1: w.data = $urandom_range(0, 175);
					2: w.data = $urandom_range(0, 7);
					default: ;
				endcase
		end else if (r < 95) begin
			w.kind = KIND_RENDER;
			if ($urandom_range(0, 9) != 0) w.line = $urandom_range(0, 143);
			if ($urandom_range(0, 1)) w.window_y = $urandom_range(0, 143);
			if ($urandom_range(0, 2) != 0) w.window_x = $urandom_range(0, 175);
		end else begin
			w.kind = KIND_NONE;
		end
		return w;
	endfunction

	task window_edges();
		send_word(mk_render(0, 0, 0, 0, 0));
		send_word(mk_render(143, 255, 255, 143, 6));
		send_word(mk_render(70, 3, 9, 0, 166));
		send_word(mk_render(70, 3, 9, 0, 167));
		send_word(mk_render(5, 0, 0, 255, 7));
	endtask

	task random_phase(int n);
		repeat (n) send_word(rand_word());
	endtask

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_word(mk(KIND_VM, 'h1000, 'hff));
		send_word(mk(KIND_VM, 'h1001, 'h0f));
		send_word(mk(KIND_VM, 'h0800, 'h3c));
		send_word(mk(KIND_VM, 'h0801, 'hc3));
		send_word(mk(KIND_VM, 'h1801, 'h80));
		send_word(mk(KIND_VM, 'h0000, 'haa));
		send_word(mk(KIND_VM, 'h0001, 'h55));
		send_word(mk(KIND_VM, 16383, 'hff));
		send_word(mk(KIND_OAM, 0, 16));
		send_word(mk(KIND_OAM, 1, 8));
		send_word(mk(KIND_OAM, 3, 'h80));
		send_word(mk(KIND_OAM, 156, 16));
		send_word(mk(KIND_OAM, 157, 167));
		send_word(mk(KIND_OAM, 159, 'h30));
		send_word(mk(KIND_OAM, 5, 0));
		send_word(mk(KIND_OAM, 8, 16));
		send_word(mk(KIND_OAM, 9, 168));
		send_word(mk(KIND_OAM, 160, 'hff));
		send_word(mk(KIND_OAM, 16383, 'hff));
		send_word(mk(KIND_NONE, 0, 0));
		send_word(mk_render(0, 0, 0, 0, 0));
		send_word(mk_render(143, 255, 255, 255, 255));
		send_word(mk_render(144, 0, 0, 0, 0));
		send_word(mk_render(255, 0, 0, 0, 0));
		random_phase(50);
		settle();

		set_regs(8'hff, 8'h1b, 8'he4, 8'h00, 1);
		window_edges();
		random_phase(55);
		settle();

		set_regs(8'h00, 8'h00, 8'h00, 8'hff, 0);
		random_phase(25);
		settle();

		set_regs(8'h7e, 8'hff, 8'h27, 8'hd2, 0);
		window_edges();
		random_phase(55);
		settle();

		set_regs(8'h67, 8'he4, 8'h1b, 8'h93, 1);
		random_phase(40);
		settle();

		set_regs($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
		random_phase(55);
		settle();

		$display("covered %0d writes and %0d visible lines over six register settings",
			sb.writes, sb.renders);
		$display("checked %0d pixel groups, %0d mismatches", sb.results, sb.errors);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
